FILE: rtl/core/p8u_pkg.sv
// ----------------------------------------------------------------------------
// p8u_pkg
// shared widths, codes and the command type of the 8-bit to 16-bit pcm
// rate upsampler
// ----------------------------------------------------------------------------
package p8u_pkg;

  localparam int BYTE_W    = 8;
  localparam int SAMPLE_W  = 16;
  localparam int RATE_W    = 16;

  localparam int DEF_FRACTION_BITS = 16;
  localparam int DEF_OUTPUT_RATE   = 44100;

  localparam int MIN_RATE    = 1000;
  localparam int MAX_COPIES  = 45;
  localparam int CNT_W       = $clog2(MAX_COPIES + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] SIGN_FLIP = 8'h80;

  // repeat mode, chosen when source_rate is written
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_X1  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_X2  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_X4  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ACC = 2'd3;

  // one converted sample and how many frames it fills
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [CNT_W-1:0]    count;
  } cmd_t;

endpackage

FILE: rtl/core/p8u_rate_cfg.sv
// ----------------------------------------------------------------------------
// p8u_rate_cfg
// holds source_rate as a repeat mode and works out the phase increment by a
// reciprocal multiplication with the output rate
// ----------------------------------------------------------------------------
module p8u_rate_cfg #(
  parameter int FRACTION_BITS = p8u_pkg::DEF_FRACTION_BITS,
  parameter int OUTPUT_RATE   = p8u_pkg::DEF_OUTPUT_RATE,
  parameter int ACC_W         = 18
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [p8u_pkg::RATE_W-1:0]          cfg_wdata,
  output logic                                busy,
  output logic [p8u_pkg::MODE_W-1:0]          mode,
  output logic [ACC_W-1:0]                    increment
);

  // rounded-up reciprocal, shifted far enough that the floor is exact for
  // every 16-bit rate
  localparam int     RECIP_SH = p8u_pkg::RATE_W + $clog2(OUTPUT_RATE);
  localparam longint RECIP    =
      ((longint'(1) << (FRACTION_BITS + RECIP_SH)) + OUTPUT_RATE - 1) / OUTPUT_RATE;
  localparam int     MW       = $clog2(RECIP + 1);
  localparam int     PW       = p8u_pkg::RATE_W + MW;

  localparam longint RST_RATE =
      longint'(OUTPUT_RATE) % (longint'(1) << p8u_pkg::RATE_W);
  localparam longint RST_CL   =
      (RST_RATE < p8u_pkg::MIN_RATE) ? p8u_pkg::MIN_RATE : RST_RATE;
  localparam longint INC_RST  = ((RST_CL << FRACTION_BITS) / OUTPUT_RATE) + 1;

  localparam logic [p8u_pkg::MODE_W-1:0] RST_MODE =
      (RST_RATE == OUTPUT_RATE)     ? p8u_pkg::MODE_X1 :
      (RST_RATE == OUTPUT_RATE / 2) ? p8u_pkg::MODE_X2 :
      (RST_RATE == OUTPUT_RATE / 4) ? p8u_pkg::MODE_X4 : p8u_pkg::MODE_ACC;

  logic [p8u_pkg::RATE_W-1:0]        rate_q;
  logic [p8u_pkg::RATE_W-1:0]        rate_cl;
  logic [p8u_pkg::MODE_W-1:0]        mode_wr;
  logic [PW-1:0]                     prod;

  always_comb begin
    prod    = PW'(rate_q) * PW'(RECIP);
    rate_cl = (32'(cfg_wdata) < 32'(p8u_pkg::MIN_RATE)) ?
              p8u_pkg::RATE_W'(p8u_pkg::MIN_RATE) : cfg_wdata;
    priority if (32'(cfg_wdata) == 32'(OUTPUT_RATE)) begin
      mode_wr = p8u_pkg::MODE_X1;
    end else if (32'(cfg_wdata) == 32'(OUTPUT_RATE / 2)) begin
      mode_wr = p8u_pkg::MODE_X2;
    end else if (32'(cfg_wdata) == 32'(OUTPUT_RATE / 4)) begin
      mode_wr = p8u_pkg::MODE_X4;
    end else begin
      mode_wr = p8u_pkg::MODE_ACC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      mode      <= RST_MODE;
      increment <= INC_RST[ACC_W-1:0];
    end else if (cfg_we) begin
      busy   <= 1'b1;
      mode   <= mode_wr;
      rate_q <= rate_cl;
    end else if (busy) begin
      busy      <= 1'b0;
      increment <= ACC_W'(prod[PW-1:RECIP_SH]) + ACC_W'(1);
    end
  end

endmodule

FILE: rtl/core/p8u_front.sv
// ----------------------------------------------------------------------------
// p8u_front
// accepts source items, converts the byte and runs the phase accumulator,
// one step per cycle, to find how many frames each item fills
// ----------------------------------------------------------------------------
module p8u_front #(
  parameter int FRACTION_BITS = p8u_pkg::DEF_FRACTION_BITS,
  parameter int ACC_W         = 18
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [p8u_pkg::BYTE_W-1:0]        s_axis_tdata,
  input  logic                              s_axis_tuser,
  input  logic                              cfg_busy,
  input  logic [p8u_pkg::MODE_W-1:0]        mode,
  input  logic [ACC_W-1:0]                  increment,
  input  logic                              q_full,
  output logic                              push,
  output p8u_pkg::cmd_t                     push_cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_STEP = 1'b1;
  localparam logic [ACC_W-1:0] ONE = ACC_W'(1) << FRACTION_BITS;

  logic                               state;
  logic [ACC_W-1:0]                   acc;
  logic [p8u_pkg::CNT_W-1:0]          cnt;
  logic [p8u_pkg::SAMPLE_W-1:0]       sample;

  logic                               accept;
  logic [ACC_W-1:0]                   acc_start;
  logic [ACC_W-1:0]                   acc_base;
  logic [ACC_W-1:0]                   acc_sum;
  logic [ACC_W-1:0]                   acc_after;
  logic [p8u_pkg::CNT_W-1:0]          cnt_base;
  logic [p8u_pkg::CNT_W-1:0]          cnt_step;
  logic [p8u_pkg::CNT_W-1:0]          fixed_cnt;
  logic                               reach;
  logic                               finish;
  logic                               skip;
  logic [p8u_pkg::SAMPLE_W-1:0]       conv;

  assign s_axis_tready = (state == ST_IDLE) && !cfg_busy && !q_full;

  always_comb begin
    accept    = s_axis_tvalid && s_axis_tready;
    conv      = {s_axis_tdata ^ p8u_pkg::SIGN_FLIP, p8u_pkg::BYTE_W'(0)};
    acc_start = s_axis_tuser ? '0 : acc;
    acc_base  = (state == ST_STEP) ? acc : acc_start;
    cnt_base  = (state == ST_STEP) ? cnt : '0;
    acc_sum   = acc_base + increment;
    cnt_step  = cnt_base + p8u_pkg::CNT_W'(1);
    reach     = (acc_sum >= ONE);
    // copy limit counts as reaching one unit, which leaves zero behind
    finish    = reach || (cnt_step == p8u_pkg::CNT_W'(p8u_pkg::MAX_COPIES));
    acc_after = reach ? (acc_sum - ONE) : '0;
    skip      = (acc_start >= ONE);
    unique case (mode)
      p8u_pkg::MODE_X1: fixed_cnt = p8u_pkg::CNT_W'(1);
      p8u_pkg::MODE_X2: fixed_cnt = p8u_pkg::CNT_W'(2);
      p8u_pkg::MODE_X4: fixed_cnt = p8u_pkg::CNT_W'(4);
      default:          fixed_cnt = p8u_pkg::CNT_W'(1);
    endcase

    push     = 1'b0;
    push_cmd = '{sample: conv, count: fixed_cnt};
    if (accept) begin
      if (mode != p8u_pkg::MODE_ACC) begin
        push = 1'b1;
      end else if (!skip && finish) begin
        push     = 1'b1;
        push_cmd = '{sample: conv, count: cnt_step};
      end
    end else if (state == ST_STEP) begin
      push     = finish;
      push_cmd = '{sample: sample, count: cnt_step};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      acc   <= '0;
    end else begin
      if (accept) begin
        sample <= conv;
        if (mode != p8u_pkg::MODE_ACC) begin
          acc <= acc_start;
        end else if (skip) begin
          acc <= acc_start - ONE;
        end else begin
          cnt <= cnt_step;
          if (finish) begin
            acc <= acc_after;
          end else begin
            acc   <= acc_sum;
            state <= ST_STEP;
          end
        end
      end else if (state == ST_STEP) begin
        cnt <= cnt_step;
        if (finish) begin
          acc   <= acc_after;
          state <= ST_IDLE;
        end else begin
          acc <= acc_sum;
        end
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("command pushed into a full queue");
  a_step_below_one: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> (acc < ONE))
    else $error("accumulator stepping at or above one unit");
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_busy |-> !s_axis_tready)
    else $error("item taken while increment is being worked out");

endmodule

FILE: rtl/core/p8u_queue.sv
// ----------------------------------------------------------------------------
// p8u_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module p8u_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  p8u_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          valid,
  output p8u_pkg::cmd_t head,
  input  logic          pop
);

  localparam int DEPTH = p8u_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  p8u_pkg::cmd_t  mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/p8u_back.sv
// ----------------------------------------------------------------------------
// p8u_back
// expands each queued command into its frames, one item per cycle while m_axis
// is not stalled, through a registered output stage
// ----------------------------------------------------------------------------
module p8u_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  p8u_pkg::cmd_t                     q_head,
  output logic                              q_pop,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [p8u_pkg::SAMPLE_W-1:0]      m_axis_tdata,
  output logic                              m_axis_tlast
);

  logic [p8u_pkg::CNT_W-1:0] idx;
  logic [p8u_pkg::CNT_W-1:0] idx_inc;
  logic                      load;
  logic                      last;

  always_comb begin
    load    = q_valid && (!m_axis_tvalid || m_axis_tready);
    idx_inc = idx + p8u_pkg::CNT_W'(1);
    last    = (idx_inc == q_head.count);
    q_pop   = load && last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= q_head.sample;
      m_axis_tlast <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      idx           <= '0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
      idx           <= last ? '0 : idx_inc;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (idx < q_head.count))
    else $error("copy index past the run length");
  a_pop_needs_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from an empty queue");
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output item changed while waiting");

endmodule

FILE: rtl/core/pcm8_to_pcm16_rate_upsampler.sv
// ----------------------------------------------------------------------------
// pcm8_to_pcm16_rate_upsampler
// turns unsigned 8-bit mono bytes into signed 16-bit frames at the output
// rate by repeating or skipping samples (zero-order hold)
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: sample_byte, tuser: start_of_sound
//  m_axis    out  tvalid/tready          tdata: pcm_sample, tlast: last_of_run
//  cfg       in   cfg_we                 cfg_wdata: source_rate
//
//  the back emits one frame a cycle while m_axis is not stalled and the front
//  takes one accumulator step a cycle; a skipped item pushes no command. a
//  source_rate write holds s_axis_tready low after it while the increment is
//  multiplied out by the output rate reciprocal. rst is synchronous and clears
//  the phase and the queue. the output register and the two-entry command
//  queue let the front take items while m_axis is stalled.
// ----------------------------------------------------------------------------
module pcm8_to_pcm16_rate_upsampler #(
  parameter int FRACTION_BITS = p8u_pkg::DEF_FRACTION_BITS,
  parameter int OUTPUT_RATE   = p8u_pkg::DEF_OUTPUT_RATE
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [p8u_pkg::BYTE_W-1:0]        s_axis_tdata,   // sample_byte
  input  logic                              s_axis_tuser,   // start_of_sound
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [p8u_pkg::SAMPLE_W-1:0]      m_axis_tdata,   // pcm_sample
  output logic                              m_axis_tlast,
  input  logic                              cfg_we,
  input  logic [p8u_pkg::RATE_W-1:0]        cfg_wdata
);

  // integer bits so that the accumulator holds one unit plus the largest step
  localparam int INT_BITS = $clog2(((1 << p8u_pkg::RATE_W) - 1) / OUTPUT_RATE + 3);
  localparam int ACC_W    = FRACTION_BITS + INT_BITS;

  logic                       cfg_busy;
  logic [p8u_pkg::MODE_W-1:0] mode;
  logic [ACC_W-1:0]           increment;
  logic                       push;
  p8u_pkg::cmd_t              push_cmd;
  logic                       q_full;
  logic                       q_valid;
  p8u_pkg::cmd_t              q_head;
  logic                       q_pop;

  p8u_rate_cfg #(
    .FRACTION_BITS (FRACTION_BITS),
    .OUTPUT_RATE   (OUTPUT_RATE),
    .ACC_W         (ACC_W)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .busy      (cfg_busy),
    .mode      (mode),
    .increment (increment)
  );

  p8u_front #(
    .FRACTION_BITS (FRACTION_BITS),
    .ACC_W         (ACC_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_busy      (cfg_busy),
    .mode          (mode),
    .increment     (increment),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  p8u_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  p8u_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for pcm8_to_pcm16_rate_upsampler: random and directed
// sample bytes go through the stream input under several source rates, and
// every output frame is checked against a zero-order-hold prediction
// ----------------------------------------------------------------------------
module testbench;

  localparam int BYTE_W            = p8u_pkg::BYTE_W;
  localparam int SAMPLE_W          = p8u_pkg::SAMPLE_W;
  localparam int RATE_W            = p8u_pkg::RATE_W;
  localparam int DEF_FRACTION_BITS = p8u_pkg::DEF_FRACTION_BITS;
  localparam int DEF_OUTPUT_RATE   = p8u_pkg::DEF_OUTPUT_RATE;
  localparam int MIN_RATE          = p8u_pkg::MIN_RATE;
  localparam int MAX_COPIES        = p8u_pkg::MAX_COPIES;

  localparam int UNIT         = 1 << DEF_FRACTION_BITS;
  localparam int IDLE_PCT     = 30;
  localparam int SETTLE       = 48;
  localparam int LONG_STALL   = 400;
  localparam int QUIET_LIMIT  = 3000;
  localparam int PHASE_ITEMS  = 25;
  localparam int PHASES       = 10;

  typedef struct {
    logic [BYTE_W-1:0] sample_byte;
    logic              start;
  } src_item_t;

  typedef struct {
    logic [SAMPLE_W-1:0] pcm;
    logic                last;
  } pcm_frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [BYTE_W-1:0]   s_axis_tdata = '0;  // sample_byte
  logic                s_axis_tuser = 1'b0; // start_of_sound
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_axis_tdata;        // pcm_sample
  logic                m_axis_tlast;
  logic                cfg_we = 1'b0;
  logic [RATE_W-1:0]   cfg_wdata = '0;

  pcm8_to_pcm16_rate_upsampler i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // bytes waiting to be sent and frames the block still owes
  src_item_t  byte_queue[$];
  pcm_frame_t expected_frames[$];

  // predictor copy of the block state
  int unsigned src_rate  = DEF_OUTPUT_RATE;
  int unsigned phase_acc = 0;
  int unsigned phase_inc;

  int mismatches     = 0;
  int items_sent     = 0;
  int frames_checked = 0;
  int rate_writes    = 0;
  int stalls_asked   = 0;
  bit steady         = 1'b0;

  function automatic int unsigned rate_step(input int unsigned rate);
    longint unsigned r;
    r = (rate < MIN_RATE) ? MIN_RATE : rate;
    return int'(((r << DEF_FRACTION_BITS) / DEF_OUTPUT_RATE) + 1);
  endfunction

  // works out the frames one accepted byte turns into
  task automatic hold_sample(input logic [BYTE_W-1:0] b, input logic start);
    logic [SAMPLE_W-1:0] pcm;
    int n;
    pcm = {~b[7], b[6:0], 8'h00};
    n = 0;
    if (start) phase_acc = 0;
    if (src_rate == DEF_OUTPUT_RATE) begin
      n = 1;
    end else if (src_rate == DEF_OUTPUT_RATE / 2) begin
      n = 2;
    end else if (src_rate == DEF_OUTPUT_RATE / 4) begin
      n = 4;
    end else if (phase_acc >= UNIT) begin
      // downsampling: this byte is dropped
      phase_acc -= UNIT;
    end else begin
      while (phase_acc < UNIT) begin
        if (n == MAX_COPIES) begin
          phase_acc = UNIT;
          break;
        end
        n++;
        phase_acc += phase_inc;
      end
      phase_acc -= UNIT;
    end
    for (int k = 0; k < n; k++) expected_frames.push_back('{pcm, k == n - 1});
  endtask

  // sender
  always @(posedge clk) begin
    src_item_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        hold_sample(s_axis_tdata, s_axis_tuser);
        items_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (byte_queue.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          it = byte_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= it.sample_byte;
          s_axis_tuser  <= it.start;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and frame check
  int stall_left = 0;
  int stalls_done = 0;

  always @(posedge clk) begin
    pcm_frame_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: frame with nothing expected: expected none, %s %h tlast %b",
                   $time, "actual pcm_sample", m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          if (m_axis_tdata !== want.pcm) begin
            $display("%0t: pcm_sample expected %h actual %h", $time, want.pcm, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: tlast expected %b actual %b", $time, want.last, m_axis_tlast);
            mismatches++;
          end
          frames_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (stalls_done < stalls_asked) begin
        // long hold-off so the block backs up into its input
        stalls_done++;
        stall_left = LONG_STALL - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on handshake activity
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("pcm8_to_pcm16_rate_upsampler regression: fail");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (byte_queue.size() != 0 || s_axis_tvalid || expected_frames.size() != 0);
  endtask

  // block must be idle; skipped bytes may still be in flight, so let it settle
  task automatic write_rate(input logic [RATE_W-1:0] rate);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= rate;
    src_rate  = rate;
    phase_inc = rate_step(rate);
    rate_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++)
      byte_queue.push_back('{BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0});
  endtask

  logic [RATE_W-1:0] phase_rates[PHASES];

  initial begin
    phase_inc = rate_step(src_rate);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes at the reset rate, then each mode and edge rate
    @(negedge clk);
    byte_queue.push_back('{8'h00, 1'b1});
    byte_queue.push_back('{8'hff, 1'b0});
    byte_queue.push_back('{8'h80, 1'b0});
    byte_queue.push_back('{8'h7f, 1'b1});
    write_rate(RATE_W'(DEF_OUTPUT_RATE / 2));
    byte_queue.push_back('{8'h01, 1'b1});
    byte_queue.push_back('{8'hfe, 1'b0});
    write_rate(RATE_W'(DEF_OUTPUT_RATE / 4));
    byte_queue.push_back('{8'h55, 1'b0});
    byte_queue.push_back('{8'haa, 1'b1});
    // lowest legal rate: the most copies per byte
    write_rate(RATE_W'(MIN_RATE));
    byte_queue.push_back('{8'h10, 1'b1});
    byte_queue.push_back('{8'h20, 1'b0});
    // below range, clamped for the step but not a repeat mode
    write_rate(RATE_W'(MIN_RATE - 1));
    byte_queue.push_back('{8'h30, 1'b1});
    write_rate('0);
    byte_queue.push_back('{8'h40, 1'b0});
    byte_queue.push_back('{8'hc0, 1'b0});
    // top rate: downsampling drops bytes, start flag mid-run
    write_rate('1);
    byte_queue.push_back('{8'h11, 1'b1});
    byte_queue.push_back('{8'h22, 1'b0});
    byte_queue.push_back('{8'h33, 1'b0});
    byte_queue.push_back('{8'h44, 1'b1});
    byte_queue.push_back('{8'h66, 1'b0});
    write_rate(16'd30000);
    byte_queue.push_back('{8'h99, 1'b1});
    byte_queue.push_back('{8'h77, 1'b0});
    byte_queue.push_back('{8'hee, 1'b0});

    phase_rates[0] = RATE_W'(DEF_OUTPUT_RATE / 2);
    phase_rates[1] = RATE_W'(MIN_RATE);
    phase_rates[2] = '1;
    phase_rates[3] = '0;
    phase_rates[4] = RATE_W'(DEF_OUTPUT_RATE);
    phase_rates[5] = RATE_W'(DEF_OUTPUT_RATE / 4);
    phase_rates[6] = 16'd48000;
    phase_rates[7] = RATE_W'($urandom_range(MIN_RATE, 65535));
    phase_rates[8] = RATE_W'($urandom_range(0, MIN_RATE - 1));
    phase_rates[9] = 16'd8000;

    for (int p = 0; p < PHASES; p++) begin
      write_rate(phase_rates[p]);
      @(negedge clk);
      steady = (p == 4);
      if (p == 6) begin
        stalls_asked++;
        queue_random(PHASE_ITEMS);
      end else if (p == 7) begin
        // sender waits out every owed frame halfway through
        queue_random(PHASE_ITEMS / 2);
        wait_drained();
        queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        queue_random(PHASE_ITEMS);
      end
      wait_drained();
      steady = 1'b0;
    end

    wait_drained();
    repeat (SETTLE) @(negedge clk);
    $display("covered %0d bytes, %0d frames checked, %0d source rate writes",
             items_sent, frames_checked, rate_writes);
    $display("rates included repeat modes, clamped low rates and downsampling");
    if (mismatches == 0) begin
      $display("pcm8_to_pcm16_rate_upsampler regression: pass");
    end else begin
      $display("pcm8_to_pcm16_rate_upsampler regression: fail");
    end
    $finish;
  end

endmodule
